// ----- rtl/core/rcev_pkg.sv -----
// ----------------------------------------------------------------------------
// rcev_pkg: shared types and constants for the real cubic escape ray unit
// Fixed-point widths, the queue entry type, state encodings and log constants.
// ----------------------------------------------------------------------------
package rcev_pkg;

    localparam int FRAC_BITS = 28;
    localparam int CNT_W     = 10;
    localparam int IN_W      = 32;

    // |x| below the escape bound of 512 fits in MAG_W bits.
    localparam int MAG_W  = FRAC_BITS + 9;
    localparam int SQ_W   = 2 * MAG_W - FRAC_BITS;
    localparam int TA_W   = 2 * IN_W - FRAC_BITS + 2;
    localparam int T_W    = (SQ_W > TA_W) ? SQ_W : TA_W;
    localparam int T_S    = T_W + 1;
    localparam int X_W    = T_W + MAG_W - FRAC_BITS + 2;
    localparam int SPLIT  = (MAG_W + 1) / 2;
    localparam int HI_W   = MAG_W - SPLIT;
    localparam int ACC_W  = T_W + MAG_W;
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;

    localparam logic [CNT_W-1:0] MAX_ITER_RESET = CNT_W'(100);
    localparam logic [T_W-1:0]   ESC_SQ = T_W'(100000) << FRAC_BITS;
    localparam logic [31:0]      LN2_Q32 = 32'd2977044472;
    localparam int               RAY_SHIFT = 14;

    // Natural log of v / 2^fb in Q.32, same algorithm as the hardware unit.
    function automatic longint ln_q32_const(input longint unsigned v, input int fb);
        int p;
        longint unsigned m;
        longint unsigned frac;
        longint unsigned fl;
        begin
            p = 63;
            frac = 0;
            if (v == 0) begin
                return 0;
            end
            while (((v >> p) & 64'd1) == 0) begin
                p = p - 1;
            end
            m = (p >= 30) ? (v >> (p - 30)) : (v << (30 - p));
            for (int k = 31; k >= 0; k--) begin
                m = (m * m) >> 30;
                if (m >= (64'd1 << 31)) begin
                    m = m >> 1;
                    frac = frac | (64'd1 << k);
                end
            end
            fl = (frac * 64'(LN2_Q32)) >> 32;
            return longint'(p - fb) * longint'(LN2_Q32) + longint'(fl);
        end
    endfunction

    localparam longint LN3_Q32 = ln_q32_const(64'd3, 0);

    typedef struct packed {
        logic signed [IN_W-1:0] a;
        logic signed [IN_W-1:0] b;
        logic [T_W-1:0]         ta;
    } rcev_item_t;

    typedef struct packed {
        logic        start;
        logic        fb32;
        logic [63:0] value;
    } rcev_ln_req_t;

    typedef struct packed {
        logic               done;
        logic signed [63:0] result;
    } rcev_ln_rsp_t;

    typedef enum logic [3:0] {
        B_IDLE, B_SQ_LO, B_SQ_HI, B_TEST, B_MU_LO, B_MU_HI, B_UPD,
        B_DECIDE, B_LSTART, B_LWAIT, B_RAY1, B_RAY2, B_RAY3, B_EMIT
    } rcev_back_state_t;

    typedef enum logic [2:0] {
        L_IDLE, L_NORM, L_SQR, L_MUL, L_SUM
    } rcev_ln_state_t;

endpackage

// ----- rtl/core/rcev_front.sv -----
// ----------------------------------------------------------------------------
// rcev_front: input stage
// Registers one (a,b) point and computes 3*a^2 before handing it to the queue.
// ----------------------------------------------------------------------------
module rcev_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [63:0]          in_data,
    output logic                 push_valid,
    input  logic                 push_ready,
    output rcev_pkg::rcev_item_t push_item
);
    import rcev_pkg::*;

    logic                   valid_reg, valid_next;
    logic signed [IN_W-1:0] a_reg, b_reg;
    logic [IN_W-1:0]        a_mag;
    logic [2*IN_W-1:0]      a_sq;
    logic [T_W-1:0]         a2;

    assign in_ready   = !valid_reg || push_ready;
    assign push_valid = valid_reg;

    always_comb begin
        a_mag = a_reg[IN_W-1] ? IN_W'(-a_reg) : IN_W'(a_reg);
        a_sq  = a_mag * a_mag;
        a2    = T_W'(a_sq >> FRAC_BITS);
        push_item.a  = a_reg;
        push_item.b  = b_reg;
        push_item.ta = (a2 << 1) + a2;
        valid_next = valid_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (push_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (in_valid && in_ready) begin
            a_reg <= in_data[IN_W-1:0];
            b_reg <= in_data[2*IN_W-1:IN_W];
        end
    end

endmodule

// ----- rtl/core/rcev_queue.sv -----
// ----------------------------------------------------------------------------
// rcev_queue: two-entry queue
// Decouples the input stage from the orbit engine.
// ----------------------------------------------------------------------------
module rcev_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  rcev_pkg::rcev_item_t push_item,
    output logic                 pop_valid,
    input  logic                 pop,
    output rcev_pkg::rcev_item_t pop_item
);
    import rcev_pkg::*;

    rcev_item_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_reg, rd_reg;
    logic [QPTR_W:0]     cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign push_ready = cnt_reg != (QPTR_W+1)'(QDEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_item   = mem_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (do_push) begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_reg <= rd_reg + 1'b1;
            end
        end
        if (do_push) begin
            mem_reg[wr_reg] <= push_item;
        end
    end

endmodule

// ----- rtl/core/rcev_ln.sv -----
// ----------------------------------------------------------------------------
// rcev_ln: iterative natural logarithm
// Normalizes the argument, then builds log2 of the mantissa one bit a cycle.
// ----------------------------------------------------------------------------
module rcev_ln (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  rcev_pkg::rcev_ln_req_t req,
    output rcev_pkg::rcev_ln_rsp_t rsp
);
    import rcev_pkg::*;

    rcev_ln_state_t     state_reg, state_next;
    logic [63:0]        m_reg, m_next;
    logic [5:0]         p_reg, p_next;
    logic [4:0]         k_reg, k_next;
    logic [31:0]        frac_reg, frac_next;
    logic               fb32_reg, fb32_next;
    logic [63:0]        prf_reg, prf_next;
    logic signed [63:0] pre_reg, pre_next;
    logic signed [63:0] res_reg, res_next;
    logic               done_reg, done_next;
    logic [61:0]        sqv;
    logic [31:0]        sqs;
    logic signed [7:0]  e;
    logic signed [40:0] pe;

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

    always_comb begin
        state_next = state_reg;
        m_next     = m_reg;
        p_next     = p_reg;
        k_next     = k_reg;
        frac_next  = frac_reg;
        fb32_next  = fb32_reg;
        prf_next   = prf_reg;
        pre_next   = pre_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        sqv = m_reg[30:0] * m_reg[30:0];
        sqs = sqv[61:30];
        e   = $signed({2'b00, p_reg}) - (fb32_reg ? 8'sd32 : 8'(FRAC_BITS));
        pe  = e * $signed({1'b0, LN2_Q32});
        case (state_reg)
            L_IDLE: begin
                if (req.start) begin
                    if (req.value == '0) begin
                        res_next  = '0;
                        done_next = 1'b1;
                    end else begin
                        m_next     = req.value;
                        p_next     = 6'd63;
                        fb32_next  = req.fb32;
                        state_next = L_NORM;
                    end
                end
            end
            L_NORM: begin
                if (m_reg[63]) begin
                    m_next     = {33'b0, m_reg[63:33]};
                    k_next     = 5'd31;
                    frac_next  = '0;
                    state_next = L_SQR;
                end else if (m_reg[63:56] == '0) begin
                    m_next = m_reg << 8;
                    p_next = p_reg - 6'd8;
                end else begin
                    m_next = m_reg << 1;
                    p_next = p_reg - 6'd1;
                end
            end
            L_SQR: begin
                if (sqs[31]) begin
                    m_next          = {33'b0, sqs[31:1]};
                    frac_next[k_reg] = 1'b1;
                end else begin
                    m_next = {32'b0, sqs};
                end
                if (k_reg == '0) begin
                    state_next = L_MUL;
                end else begin
                    k_next = k_reg - 1'b1;
                end
            end
            L_MUL: begin
                prf_next   = frac_reg * LN2_Q32;
                pre_next   = 64'(pe);
                state_next = L_SUM;
            end
            L_SUM: begin
                res_next   = pre_reg + $signed({32'b0, prf_reg[63:32]});
                done_next  = 1'b1;
                state_next = L_IDLE;
            end
            default: state_next = L_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        m_reg    <= m_next;
        p_reg    <= p_next;
        k_reg    <= k_next;
        frac_reg <= frac_next;
        fb32_reg <= fb32_next;
        prf_reg  <= prf_next;
        pre_reg  <= pre_next;
        res_reg  <= res_next;
    end

endmodule

// ----- rtl/core/rcev_back.sv -----
// ----------------------------------------------------------------------------
// rcev_back: orbit engine and result stage
// Runs both critical orbits on one split multiplier, then, when both escape, the log-log step.
// ----------------------------------------------------------------------------
module rcev_back (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [rcev_pkg::CNT_W-1:0] max_iter,
    input  logic                     item_valid,
    output logic                     item_pop,
    input  rcev_pkg::rcev_item_t     item,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [31:0]              out_ray,
    output logic                     out_not_esc,
    output logic [rcev_pkg::CNT_W-1:0] out_first,
    output logic [rcev_pkg::CNT_W-1:0] out_second
);
    import rcev_pkg::*;

    rcev_back_state_t       state_reg, state_next;
    rcev_item_t             it_reg, it_next;
    logic [CNT_W-1:0]       n_reg, n_next, i_reg, i_next, j_reg, j_next;
    logic signed [X_W-1:0]  x_reg, x_next, x1_reg, x1_next, x2_reg, x2_next;
    logic signed [T_S-1:0]  t_reg, t_next;
    logic [ACC_W-1:0]       acc_reg, acc_next;
    logic                   orbit_reg, orbit_next;
    logic [1:0]             lidx_reg, lidx_next;
    logic signed [63:0]     l_reg [4];
    logic signed [63:0]     dprod_reg, dprod_next, td_reg, td_next;
    logic [31:0]            ray_reg, ray_next;
    logic                   ov_reg, ov_next, ne_reg, ne_next;
    logic [31:0]            oray_reg;
    logic                   one_reg;
    logic [CNT_W-1:0]       of_reg, os_reg;
    logic                   load_out;

    logic [X_W-1:0]         x_mag, xo_mag;
    logic                   big;
    logic [T_W-1:0]         t_mag, a_op, sq;
    logic [SPLIT-1:0]       b_op;
    logic [T_W+SPLIT-1:0]   mul_p;
    logic [X_W-3:0]         prodm;
    logic signed [X_W-1:0]  prods;
    rcev_ln_req_t           lreq;
    rcev_ln_rsp_t           lrsp;
    logic [63:0]            lsrc;
    logic signed [CNT_W:0]  dif;
    logic signed [34:0]     ln3;
    logic signed [45:0]     dmul;
    logic signed [63:0]     tadj, rq;

    rcev_ln u_ln (.aclk(aclk), .aresetn(aresetn), .req(lreq), .rsp(lrsp));

    assign out_valid   = ov_reg;
    assign out_ray     = oray_reg;
    assign out_not_esc = one_reg;
    assign out_first   = of_reg;
    assign out_second  = os_reg;
    assign ln3         = 35'(LN3_Q32);

    always_comb begin
        x_mag = x_reg[X_W-1] ? X_W'(-x_reg) : X_W'(x_reg);
        big   = |x_mag[X_W-1:MAG_W];
        t_mag = t_reg[T_S-1] ? T_W'(-t_reg) : T_W'(t_reg);
        a_op  = (state_reg == B_MU_LO || state_reg == B_MU_HI) ? t_mag
                                                                 : T_W'(x_mag[MAG_W-1:0]);
        b_op  = (state_reg == B_SQ_HI || state_reg == B_MU_HI) ? SPLIT'(x_mag[MAG_W-1:SPLIT])
                                                                 : x_mag[SPLIT-1:0];
        mul_p = a_op * b_op;
        sq    = acc_reg[FRAC_BITS +: T_W];
        prodm = acc_reg[FRAC_BITS +: X_W-2];
        prods = (t_reg[T_S-1] ^ x_reg[X_W-1]) ? -$signed({2'b00, prodm})
                                              : $signed({2'b00, prodm});
        case (lidx_reg)
            2'd0: begin
                xo_mag = x1_reg[X_W-1] ? X_W'(-x1_reg) : X_W'(x1_reg);
                lsrc   = 64'(xo_mag);
            end
            2'd1: begin
                xo_mag = x2_reg[X_W-1] ? X_W'(-x2_reg) : X_W'(x2_reg);
                lsrc   = 64'(xo_mag);
            end
            2'd2: begin
                xo_mag = '0;
                lsrc   = (l_reg[0] > 0) ? (l_reg[0] << 1) : '0;
            end
            default: begin
                xo_mag = '0;
                lsrc   = (l_reg[1] > 0) ? (l_reg[1] << 1) : '0;
            end
        endcase
        lreq.start = state_reg == B_LSTART;
        lreq.fb32  = lidx_reg[1];
        lreq.value = lsrc;
        dif  = $signed({1'b0, j_reg}) - $signed({1'b0, i_reg});
        dmul = ln3 * dif;
        tadj = td_reg[63] ? td_reg + 64'sd16383 : td_reg;
        rq   = tadj >>> RAY_SHIFT;
    end

    always_comb begin
        state_next = state_reg;
        it_next    = it_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        x_next     = x_reg;
        x1_next    = x1_reg;
        x2_next    = x2_reg;
        t_next     = t_reg;
        acc_next   = acc_reg;
        orbit_next = orbit_reg;
        lidx_next  = lidx_reg;
        dprod_next = dprod_reg;
        td_next    = td_reg;
        ray_next   = ray_reg;
        ne_next    = ne_reg;
        item_pop   = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            B_IDLE: begin
                if (item_valid) begin
                    item_pop   = 1'b1;
                    it_next    = item;
                    x_next     = X_W'(item.a);
                    n_next     = '0;
                    orbit_next = 1'b0;
                    state_next = B_SQ_LO;
                end
            end
            B_SQ_LO: begin
                acc_next = ACC_W'(mul_p);
                if (n_reg >= max_iter || big) begin
                    if (!orbit_reg) begin
                        i_next     = n_reg;
                        x1_next    = x_reg;
                        x_next     = -X_W'(it_reg.a);
                        n_next     = '0;
                        orbit_next = 1'b1;
                    end else begin
                        j_next     = n_reg;
                        x2_next    = x_reg;
                        state_next = B_DECIDE;
                    end
                end else begin
                    state_next = B_SQ_HI;
                end
            end
            B_SQ_HI: begin
                acc_next   = acc_reg + (ACC_W'(mul_p) << SPLIT);
                state_next = B_TEST;
            end
            B_TEST: begin
                if (sq >= ESC_SQ) begin
                    if (!orbit_reg) begin
                        i_next     = n_reg;
                        x1_next    = x_reg;
                        x_next     = -X_W'(it_reg.a);
                        n_next     = '0;
                        orbit_next = 1'b1;
                        state_next = B_SQ_LO;
                    end else begin
                        j_next     = n_reg;
                        x2_next    = x_reg;
                        state_next = B_DECIDE;
                    end
                end else begin
                    t_next     = $signed({1'b0, sq}) - $signed({1'b0, it_reg.ta});
                    state_next = B_MU_LO;
                end
            end
            B_MU_LO: begin
                acc_next   = ACC_W'(mul_p);
                state_next = B_MU_HI;
            end
            B_MU_HI: begin
                acc_next   = acc_reg + (ACC_W'(mul_p) << SPLIT);
                state_next = B_UPD;
            end
            B_UPD: begin
                x_next     = prods + X_W'(it_reg.b);
                n_next     = n_reg + 1'b1;
                state_next = B_SQ_LO;
            end
            B_DECIDE: begin
                if (i_reg >= max_iter || j_reg >= max_iter) begin
                    ne_next    = 1'b1;
                    ray_next   = '0;
                    state_next = B_EMIT;
                end else begin
                    ne_next    = 1'b0;
                    lidx_next  = '0;
                    state_next = B_LSTART;
                end
            end
            B_LSTART: state_next = B_LWAIT;
            B_LWAIT: begin
                if (lrsp.done) begin
                    if (lidx_reg == 2'd3) begin
                        state_next = B_RAY1;
                    end else begin
                        lidx_next  = lidx_reg + 1'b1;
                        state_next = B_LSTART;
                    end
                end
            end
            B_RAY1: begin
                dprod_next = 64'(dmul);
                state_next = B_RAY2;
            end
            B_RAY2: begin
                td_next    = l_reg[3] - l_reg[2] - dprod_reg;
                state_next = B_RAY3;
            end
            B_RAY3: begin
                if (rq > 64'sd2147483647) begin
                    ray_next = 32'h7FFF_FFFF;
                end else if (rq < -64'sd2147483648) begin
                    ray_next = 32'h8000_0000;
                end else begin
                    ray_next = rq[31:0];
                end
                state_next = B_EMIT;
            end
            B_EMIT: begin
                if (!ov_reg || out_ready) begin
                    load_out   = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
        ov_next = ov_reg;
        if (load_out) begin
            ov_next = 1'b1;
        end else if (out_ready) begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
        it_reg    <= it_next;
        n_reg     <= n_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        x_reg     <= x_next;
        x1_reg    <= x1_next;
        x2_reg    <= x2_next;
        t_reg     <= t_next;
        acc_reg   <= acc_next;
        orbit_reg <= orbit_next;
        lidx_reg  <= lidx_next;
        dprod_reg <= dprod_next;
        td_reg    <= td_next;
        ray_reg   <= ray_next;
        ne_reg    <= ne_next;
        if (state_reg == B_LWAIT && lrsp.done) begin
            l_reg[lidx_reg] <= lrsp.result;
        end
        if (load_out) begin
            oray_reg <= ray_reg;
            one_reg  <= ne_reg;
            of_reg   <= i_reg;
            os_reg   <= j_reg;
        end
    end

endmodule

// ----- rtl/core/real_cubic_escape_ray_value_unit.sv -----
// ----------------------------------------------------------------------------
// real_cubic_escape_ray_value_unit: escape-time ray value for the real cubic
// Accepts (a,b) points, runs both critical orbits and returns the ray value.
// ----------------------------------------------------------------------------
// Each orbit runs at most max_iterations steps on one split multiplier, and
// four logarithms follow when both orbits escape. The engine works on one
// point at a time; the input stage and a two-entry queue accept up to three
// further points while the engine works.
// Reset: synchronous, active low; clears control state, max_iterations = 100.
module real_cubic_escape_ray_value_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] a_coord, [63:32] b_coord
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [31:0] ray_value, [41:32] first_count,
                                   // [51:42] second_count, [55:52] zero
    output logic        m_tuser,   // [0] not_escaped
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [9:0]  cfg_data
);
    import rcev_pkg::*;

    logic [CNT_W-1:0] max_iter_reg;
    logic             push_valid, push_ready, pop_valid, pop;
    rcev_item_t       push_item, pop_item;
    logic [31:0]      ray;
    logic [CNT_W-1:0] first_cnt, second_cnt;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_iter_reg <= MAX_ITER_RESET;
        end else if (cfg_valid && cfg_ready) begin
            max_iter_reg <= cfg_data;
        end
    end

    rcev_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata),
        .push_valid(push_valid), .push_ready(push_ready), .push_item(push_item)
    );

    rcev_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push_valid(push_valid), .push_ready(push_ready), .push_item(push_item),
        .pop_valid(pop_valid), .pop(pop), .pop_item(pop_item)
    );

    rcev_back u_back (
        .aclk(aclk), .aresetn(aresetn), .max_iter(max_iter_reg),
        .item_valid(pop_valid), .item_pop(pop), .item(pop_item),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_ray(ray),
        .out_not_esc(m_tuser), .out_first(first_cnt), .out_second(second_cnt)
    );

    assign m_tdata = {4'b0, second_cnt, first_cnt, ray};

endmodule

// ----- rtl/core/rcev_checker.sv -----
// ----------------------------------------------------------------------------
// rcev_checker: port-level assertions for the escape ray unit
// Watches the result channel over time; bound to the top level.
// ----------------------------------------------------------------------------
module rcev_port_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tuser
);

    // No result may appear in the cycle after reset.
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // A point that did not escape carries a zero ray value.
    a_zero_ray: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[31:0] == 32'd0)
        else $error("non-zero ray value on a non-escaped point");

    // An escaped orbit always takes at least one step from a critical point.
    a_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[41:32] != 10'd0 && m_tdata[51:42] != 10'd0)
        else $error("escaped result with a zero step count");

endmodule

bind real_cubic_escape_ray_value_unit rcev_port_checker u_rcev_checker (.*);
